### rtl/ptc_pkg.sv
package ptc_pkg;

  localparam int unsigned CalW = 48;
  localparam int unsigned AdcW = 20;
  localparam int unsigned WordW = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegTempCal = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPressCalA = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPressCalB = 2'd2;
  localparam logic [CfgIdxW-1:0] RegPressCalC = 2'd3;

  localparam logic [WordW-1:0] POffset = 32'd64000;
  localparam logic [WordW-1:0] PBase = 32'd1048576;
  localparam logic [WordW-1:0] PScale = 32'd3125;
  localparam logic [WordW-1:0] TRound = 32'd128;
  localparam logic [WordW-1:0] POne = 32'd32768;

  typedef struct packed {
    logic [WordW-1:0] t1, t2, t3;
    logic [WordW-1:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  } cal_t;

  // Arithmetic shift of a 32-bit word.
  function automatic logic [WordW-1:0] sar(input logic [WordW-1:0] x, input int unsigned n);
    sar = WordW'($signed(x) >>> n);
  endfunction

  function automatic logic [WordW-1:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

endpackage

### rtl/ptc_cal_regs.sv
module ptc_cal_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ptc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [ptc_pkg::CalW-1:0]        cfg_data_i,
  output ptc_pkg::cal_t                   cal_o
);

  logic [ptc_pkg::CalW-1:0] reg_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) reg_q[i] <= '0;
    end else if (cfg_we_i) begin
      reg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_comb begin
    cal_o.t1 = {16'd0, reg_q[ptc_pkg::RegTempCal][15:0]};
    cal_o.t2 = ptc_pkg::sx16(reg_q[ptc_pkg::RegTempCal][31:16]);
    cal_o.t3 = ptc_pkg::sx16(reg_q[ptc_pkg::RegTempCal][47:32]);
    cal_o.p1 = {16'd0, reg_q[ptc_pkg::RegPressCalA][15:0]};
    cal_o.p2 = ptc_pkg::sx16(reg_q[ptc_pkg::RegPressCalA][31:16]);
    cal_o.p3 = ptc_pkg::sx16(reg_q[ptc_pkg::RegPressCalA][47:32]);
    cal_o.p4 = ptc_pkg::sx16(reg_q[ptc_pkg::RegPressCalB][15:0]);
    cal_o.p5 = ptc_pkg::sx16(reg_q[ptc_pkg::RegPressCalB][31:16]);
    cal_o.p6 = ptc_pkg::sx16(reg_q[ptc_pkg::RegPressCalB][47:32]);
    cal_o.p7 = ptc_pkg::sx16(reg_q[ptc_pkg::RegPressCalC][15:0]);
    cal_o.p8 = ptc_pkg::sx16(reg_q[ptc_pkg::RegPressCalC][31:16]);
    cal_o.p9 = ptc_pkg::sx16(reg_q[ptc_pkg::RegPressCalC][47:32]);
  end

endmodule

### rtl/ptc_divider.sv
// Pipelined restoring divider, one quotient bit per stage, 32 stages.
module ptc_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [ptc_pkg::WordW-1:0]   num_i,
  input  logic [ptc_pkg::WordW-1:0]   den_i,
  input  logic                        dbl_i,
  input  logic [ptc_pkg::WordW-1:0]   side_i,
  input  logic                        pv_i,
  output logic                        valid_o,
  output logic [ptc_pkg::WordW-1:0]   quo_o,
  output logic                        dbl_o,
  output logic [ptc_pkg::WordW-1:0]   side_o,
  output logic                        pv_o
);
  localparam int unsigned W = ptc_pkg::WordW;

  logic         v_q   [W+1];
  logic [W-1:0] rem_q [W+1];
  logic [W-1:0] num_q [W+1];
  logic [W-1:0] den_q [W+1];
  logic         dbl_q [W+1];
  logic [W-1:0] side_q[W+1];
  logic         pv_q  [W+1];

  always_comb begin
    v_q[0] = valid_i; rem_q[0] = '0; num_q[0] = num_i; den_q[0] = den_i;
    dbl_q[0] = dbl_i; side_q[0] = side_i; pv_q[0] = pv_i;
  end

  for (genvar s = 0; s < W; s++) begin : g_st
    logic [W:0] trial;
    logic [W:0] diff;
    assign trial = {rem_q[s], num_q[s][W-1]};
    assign diff = trial - {1'b0, den_q[s]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (en_i) begin
        v_q[s+1] <= v_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= diff[W] ? trial[W-1:0] : diff[W-1:0];
        num_q[s+1] <= {num_q[s][W-2:0], ~diff[W]};
        den_q[s+1] <= den_q[s];
        dbl_q[s+1] <= dbl_q[s];
        side_q[s+1] <= side_q[s];
        pv_q[s+1] <= pv_q[s];
      end
    end
  end

  assign valid_o = v_q[W];
  assign quo_o = num_q[W];
  assign dbl_o = dbl_q[W];
  assign side_o = side_q[W];
  assign pv_o = pv_q[W];

endmodule

### rtl/pressure_temperature_compensation.sv
// Barometric compensation pipeline.
// Slave stream s_axis carries one reading pair per word; master stream
// m_axis returns one compensated result per word in the same order.
// Calibration is written through cfg_we_i/cfg_idx_i/cfg_data_i while idle;
// indexes 0..3 select temp_cal, press_cal_a, press_cal_b, press_cal_c.
// Throughput: one word per cycle while the receiver does not stall. The
// pipeline has 45 register stages: 10 arithmetic stages, the 32-stage
// bit-per-stage divider, two final correction stages and the output
// register.
// The whole pipeline advances only when the output register is empty or
// being drained; when the receiver stalls, every stage holds, so nothing
// is lost or repeated and s_axis_tready drops.
// Reset clears all valid bits and the calibration registers.
module pressure_temperature_compensation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // adc_temp[19:0], adc_press[39:20]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // temperature[31:0], pressure[63:32]
  output logic        m_axis_tuser    // pressure_valid
);
  localparam int unsigned W = ptc_pkg::WordW;
  localparam int unsigned NS = 10;

  ptc_pkg::cal_t cal;
  ptc_cal_regs u_cal (.clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cal_o(cal));

  logic en;
  logic out_v_q;
  assign en = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  // Generic register slots per stage: slots 0..3 hold intermediates.
  logic [W-1:0] r_q [NS+1][8];
  logic [W-1:0] r_d [NS+1][8];
  logic         v_q [NS+1];

  always_comb begin
    for (int s = 0; s <= NS; s++) for (int k = 0; k < 8; k++) r_d[s][k] = '0;
    // stage 1: temperature differences; slot 6 = ap, slot 7 = temperature
    r_d[1][0] = {15'd0, s_axis_tdata[19:3]} - {cal.t1[30:0], 1'b0};
    r_d[1][1] = {16'd0, s_axis_tdata[19:4]} - cal.t1;
    r_d[1][6] = {12'd0, s_axis_tdata[39:20]};
    // stage 2
    r_d[2][0] = W'(r_q[1][0] * cal.t2);
    r_d[2][1] = W'(r_q[1][1] * r_q[1][1]);
    r_d[2][6] = r_q[1][6];
    // stage 3
    r_d[3][0] = ptc_pkg::sar(r_q[2][0], 11);
    r_d[3][1] = W'(ptc_pkg::sar(r_q[2][1], 12) * cal.t3);
    r_d[3][6] = r_q[2][6];
    // stage 4: fine
    r_d[4][0] = r_q[3][0] + ptc_pkg::sar(r_q[3][1], 14);
    r_d[4][6] = r_q[3][6];
    // stage 5: temp product and pressure a
    r_d[5][7] = W'(r_q[4][0] * 32'd5);
    r_d[5][0] = ptc_pkg::sar(r_q[4][0], 1) - ptc_pkg::POffset;
    r_d[5][6] = r_q[4][6];
    // stage 6
    r_d[6][7] = ptc_pkg::sar(r_q[5][7] + ptc_pkg::TRound, 8);
    r_d[6][0] = r_q[5][0];
    r_d[6][1] = W'(ptc_pkg::sar(r_q[5][0], 2) * ptc_pkg::sar(r_q[5][0], 2));
    r_d[6][2] = W'(r_q[5][0] * cal.p5);
    r_d[6][3] = W'(cal.p2 * r_q[5][0]);
    r_d[6][6] = r_q[5][6];
    // stage 7
    r_d[7][7] = r_q[6][7];
    r_d[7][0] = W'(ptc_pkg::sar(r_q[6][1], 11) * cal.p6);
    r_d[7][1] = W'(cal.p3 * ptc_pkg::sar(r_q[6][1], 13));
    r_d[7][2] = {r_q[6][2][W-2:0], 1'b0};
    r_d[7][3] = ptc_pkg::sar(r_q[6][3], 1);
    r_d[7][6] = r_q[6][6];
    // stage 8: b and a partial
    r_d[8][7] = r_q[7][7];
    r_d[8][0] = ptc_pkg::sar(r_q[7][0] + r_q[7][2], 2) + {cal.p4[15:0], 16'd0};
    r_d[8][1] = ptc_pkg::sar(ptc_pkg::sar(r_q[7][1], 3) + r_q[7][3], 18) + ptc_pkg::POne;
    r_d[8][6] = r_q[7][6];
    // stage 9: divisor and numerator base
    r_d[9][7] = r_q[8][7];
    r_d[9][1] = ptc_pkg::sar(W'(r_q[8][1] * cal.p1), 15);
    r_d[9][0] = (ptc_pkg::PBase - r_q[8][6]) - ptc_pkg::sar(r_q[8][0], 12);
    // stage 10: numerator scale
    r_d[10][7] = r_q[9][7];
    r_d[10][1] = r_q[9][1];
    r_d[10][0] = W'(r_q[9][0] * ptc_pkg::PScale);
  end

  for (genvar s = 1; s <= 10; s++) begin : g_front
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[s] <= 1'b0;
      else if (en) v_q[s] <= (s == 1) ? s_axis_tvalid : v_q[s-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) for (int k = 0; k < 8; k++) r_q[s][k] <= r_d[s][k];
    end
  end
  assign v_q[0] = 1'b0;
  for (genvar k = 0; k < 8; k++) begin : g_z
    assign r_q[0][k] = '0;
  end

  // Divider
  logic [W-1:0] num, den;
  logic dbl, pv;
  assign pv = r_q[10][1] != '0;
  assign dbl = r_q[10][0][W-1];
  assign num = dbl ? r_q[10][0] : {r_q[10][0][W-2:0], 1'b0};
  assign den = pv ? r_q[10][1] : 32'd1;

  logic dv_v, dv_dbl, dv_pv;
  logic [W-1:0] dv_q, dv_t;
  ptc_divider u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_q[10]), .num_i(num), .den_i(den),
    .dbl_i(dbl), .side_i(r_q[10][7]), .pv_i(pv),
    .valid_o(dv_v), .quo_o(dv_q), .dbl_o(dv_dbl), .side_o(dv_t), .pv_o(dv_pv)
  );

  // Back end: three stages of final correction.
  logic [W-1:0] b1_p_q, b1_t_q, b1_a_q, b1_b_q;
  logic [W-1:0] b2_p_q, b2_t_q, b2_a_q, b2_b_q;
  logic b1_v_q, b1_pv_q, b2_v_q, b2_pv_q;
  logic [W-1:0] pq, bp;
  assign pq = dv_dbl ? {dv_q[W-2:0], 1'b0} : dv_q;
  assign bp = {3'd0, pq[W-1:3]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0; b2_v_q <= 1'b0; out_v_q <= 1'b0;
    end else if (en) begin
      b1_v_q <= dv_v; b2_v_q <= b1_v_q; out_v_q <= b2_v_q;
    end
  end

  // The square of p >> 3 is registered, so its product with P9 is formed in the next stage.
  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_p_q <= pq; b1_t_q <= dv_t; b1_pv_q <= dv_pv;
      b1_a_q <= W'(bp * bp);
      b1_b_q <= ptc_pkg::sar(W'({2'd0, pq[W-1:2]} * cal.p8), 13);
      b2_p_q <= b1_p_q; b2_t_q <= b1_t_q; b2_pv_q <= b1_pv_q; b2_b_q <= b1_b_q;
      b2_a_q <= W'(cal.p9 * {13'd0, b1_a_q[W-1:13]});
      m_axis_tdata[31:0] <= b2_t_q;
      m_axis_tdata[63:32] <= b2_pv_q ?
        b2_p_q + ptc_pkg::sar(ptc_pkg::sar(b2_a_q, 12) + b2_b_q + cal.p7, 4) : '0;
      m_axis_tuser <= b2_pv_q;
    end
  end
  assign m_axis_tvalid = out_v_q;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready mismatch");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[63:32] == '0)
    else $error("invalid pressure not zero");
`endif

endmodule

### bench/tb_pressure_temperature_compensation.sv
module tb_pressure_temperature_compensation;

  typedef struct packed {
    logic [31:0] temperature;
    logic [31:0] pressure;
    logic        pressure_valid;
  } comp_t;

  typedef struct {
    logic        is_cfg;
    logic [1:0]  idx;
    logic [47:0] cal;
    logic [19:0] adc_t;
    logic [19:0] adc_p;
    logic        chk;
    comp_t       want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [47:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // adc_temp[19:0], adc_press[39:20]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // temperature[31:0], pressure[63:32]
  logic        m_axis_tuser;        // pressure_valid

  logic [47:0] cal_regs [4];
  comp_t       pending [$];
  int          errors = 0;
  int          n_words = 0;
  int          n_invalid = 0;
  int          cycles = 0;
  logic        hold_off = 1'b0;

  pressure_temperature_compensation uut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [31:0] asr(logic [31:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [31:0] s16(logic [47:0] r, int pos);
    return {{16{r[pos+15]}}, r[pos +: 16]};
  endfunction

  function automatic comp_t compensate(logic [19:0] at_raw, logic [19:0] ap_raw);
    logic [31:0] at, ap, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, b, d, fine, q, p;
    comp_t r;
    at = at_raw;
    ap = ap_raw;
    t1 = cal_regs[ptc_pkg::RegTempCal][15:0];
    t2 = s16(cal_regs[ptc_pkg::RegTempCal], 16);
    t3 = s16(cal_regs[ptc_pkg::RegTempCal], 32);
    p1 = cal_regs[ptc_pkg::RegPressCalA][15:0];
    p2 = s16(cal_regs[ptc_pkg::RegPressCalA], 16);
    p3 = s16(cal_regs[ptc_pkg::RegPressCalA], 32);
    p4 = s16(cal_regs[ptc_pkg::RegPressCalB], 0);
    p5 = s16(cal_regs[ptc_pkg::RegPressCalB], 16);
    p6 = s16(cal_regs[ptc_pkg::RegPressCalB], 32);
    p7 = s16(cal_regs[ptc_pkg::RegPressCalC], 0);
    p8 = s16(cal_regs[ptc_pkg::RegPressCalC], 16);
    p9 = s16(cal_regs[ptc_pkg::RegPressCalC], 32);
    a = asr(((at >> 3) - (t1 << 1)) * t2, 11);
    d = (at >> 4) - t1;
    b = asr(asr(d * d, 12) * t3, 14);
    fine = a + b;
    r.temperature = asr(fine * 32'd5 + 32'd128, 8);
    a = asr(fine, 1) - 32'd64000;
    q = asr(a, 2);
    b = asr(q * q, 11) * p6;
    b = b + ((a * p5) << 1);
    b = asr(b, 2) + (p4 << 16);
    a = asr(asr(p3 * asr(q * q, 13), 3) + asr(p2 * a, 1), 18);
    a = asr((32'd32768 + a) * p1, 15);
    if (a == 0) begin
      r.pressure = '0;
      r.pressure_valid = 1'b0;
    end else begin
      p = ((32'd1048576 - ap) - asr(b, 12)) * 32'd3125;
      if (p < 32'h8000_0000) p = (p << 1) / a;
      else p = (p / a) * 32'd2;
      q = p >> 3;
      a = asr(p9 * ((q * q) >> 13), 12);
      b = asr((p >> 2) * p8, 13);
      r.pressure = p + asr(a + b + p7, 4);
      r.pressure_valid = 1'b1;
    end
    return r;
  endfunction

  // Receiver: random stalls, long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else if (cycles % 600 < 150) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk_i) begin
    comp_t got, exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser};
      n_words++;
      if (!got.pressure_valid) n_invalid++;
      if (pending.size() == 0) begin
        $error("unexpected result word %h", got);
        errors++;
      end else begin
        exp_r = pending.pop_front();
        if (got.temperature !== exp_r.temperature) begin
          $error("temperature: expected %h, got %h", exp_r.temperature, got.temperature);
          errors++;
        end
        if (got.pressure !== exp_r.pressure) begin
          $error("pressure: expected %h, got %h", exp_r.pressure, got.pressure);
          errors++;
        end
        if (got.pressure_valid !== exp_r.pressure_valid) begin
          $error("pressure_valid: expected %b, got %b",
                 exp_r.pressure_valid, got.pressure_valid);
          errors++;
        end
      end
    end
  end

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_cal(logic [1:0] idx, logic [47:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    cal_regs[idx] = v;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // Sends one reading pair; chk lets a directed row fix its result.
  task automatic send_pair(logic [19:0] at, logic [19:0] ap, logic chk, comp_t want);
    comp_t e;
    e = compensate(at, ap);
    if (chk && e !== want) begin
      $error("directed row: expected %h, predictor %h", want, e);
      errors++;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {ap, at};
    do @(posedge clk_i); while (!s_axis_tready);
    pending.push_back(e);
  endtask

  task automatic idle_gap();
    s_axis_tvalid <= 1'b0;
    repeat ($urandom_range(1, 4)) @(posedge clk_i);
  endtask

  function automatic logic [47:0] rand_cal(int k);
    case (k)
      0: return '0;
      1: return '1;
      2: return {16'h7FFF, 16'h7FFF, 16'hFFFF};
      3: return {16'h8000, 16'h8000, 16'h0001};
      default: return 48'({$urandom(), $urandom()});
    endcase
  endfunction

  // Typical sensor calibration with signs consistent with real parts.
  function automatic logic [47:0] typ_cal(int r);
    case (r)
      0: return {16'hFC18 ^ 16'($urandom_range(0, 255)),
                 16'd26435 + 16'($urandom_range(0, 999)),
                 16'd27504 + 16'($urandom_range(0, 999))};
      1: return {16'd3024 + 16'($urandom_range(0, 99)), 16'hD5AB,
                 16'd36477 + 16'($urandom_range(0, 999))};
      2: return {16'hFFF9, 16'd140 + 16'($urandom_range(0, 9)),
                 16'd2855 + 16'($urandom_range(0, 99))};
      default: return {16'd6000 + 16'($urandom_range(0, 99)), 16'hBFF9, 16'd15500};
    endcase
  endfunction

  initial begin
    row_t dir [$];
    row_t rw;
    int   burst;
    comp_t zero_res;
    zero_res = '0;
    for (int i = 0; i < 4; i++) cal_regs[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset all calibration is zero: temperature rounds to 0 and the
    // divisor is zero, so pressure is flagged invalid.
    rw = '{1'b0, 2'd0, '0, 20'h00000, 20'h00000, 1'b1, zero_res}; dir.push_back(rw);
    rw = '{1'b0, 2'd0, '0, 20'hFFFFF, 20'hFFFFF, 1'b1, zero_res}; dir.push_back(rw);
    rw = '{1'b1, ptc_pkg::RegTempCal, {16'hFC18, 16'd26435, 16'd27504}, '0, '0, 1'b0,
           zero_res};
    dir.push_back(rw);
    rw = '{1'b1, ptc_pkg::RegPressCalA, {16'h0BD0, 16'hD5AB, 16'd36477}, '0, '0, 1'b0,
           zero_res};
    dir.push_back(rw);
    rw = '{1'b1, ptc_pkg::RegPressCalB, {16'hFFF9, 16'd140, 16'd2855}, '0, '0, 1'b0,
           zero_res};
    dir.push_back(rw);
    rw = '{1'b1, ptc_pkg::RegPressCalC, {16'd6000, 16'hBFF9, 16'd15500}, '0, '0, 1'b0,
           zero_res};
    dir.push_back(rw);
    rw = '{1'b0, 2'd0, '0, 20'd519888, 20'd415148, 1'b0, zero_res}; dir.push_back(rw);
    rw = '{1'b0, 2'd0, '0, 20'h00000, 20'hFFFFF, 1'b0, zero_res}; dir.push_back(rw);
    rw = '{1'b0, 2'd0, '0, 20'hFFFFF, 20'h00000, 1'b0, zero_res}; dir.push_back(rw);
    rw = '{1'b0, 2'd0, '0, 20'hAAAAA, 20'h55555, 1'b0, zero_res}; dir.push_back(rw);
    rw = '{1'b0, 2'd0, '0, 20'h55555, 20'hAAAAA, 1'b0, zero_res}; dir.push_back(rw);
    // Calibration extremes: all ones, then largest positive words.
    rw = '{1'b1, ptc_pkg::RegPressCalA, '1, '0, '0, 1'b0, zero_res}; dir.push_back(rw);
    rw = '{1'b1, ptc_pkg::RegTempCal, {16'h7FFF, 16'h7FFF, 16'hFFFF}, '0, '0, 1'b0,
           zero_res};
    dir.push_back(rw);
    rw = '{1'b0, 2'd0, '0, 20'hFFFFF, 20'hFFFFF, 1'b0, zero_res}; dir.push_back(rw);
    rw = '{1'b0, 2'd0, '0, 20'h00000, 20'h00000, 1'b0, zero_res}; dir.push_back(rw);
    // P1 of zero forces a zero divisor whatever the reading.
    rw = '{1'b1, ptc_pkg::RegPressCalA, {16'h1234, 16'h8000, 16'h0000}, '0, '0, 1'b0,
           zero_res};
    dir.push_back(rw);
    rw = '{1'b0, 2'd0, '0, 20'h80000, 20'h12345, 1'b0, zero_res}; dir.push_back(rw);

    foreach (dir[i]) begin
      if (dir[i].is_cfg) begin
        s_axis_tvalid <= 1'b0;
        drain();
        write_cal(dir[i].idx, dir[i].cal);
        cfg_we_i <= 1'b0;
      end else begin
        send_pair(dir[i].adc_t, dir[i].adc_p, dir[i].chk, dir[i].want);
      end
    end
    s_axis_tvalid <= 1'b0;

    // Random phases: extreme, random and realistic calibration sets.
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      for (int r = 0; r < 4; r++) write_cal(2'(r), ph >= 5 ? typ_cal(r) : rand_cal(ph));
      cfg_we_i <= 1'b0;
      if (ph == 6) begin
        hold_off = 1'b1;
        fork
          begin
            repeat (200) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 50;) begin
        burst = $urandom_range(1, 12);
        for (int k = 0; k < burst && n < 50; k++, n++)
          if (ph >= 5)
            send_pair(20'd400000 + 20'($urandom_range(0, 250000)),
                      20'd250000 + 20'($urandom_range(0, 300000)), 1'b0, zero_res);
          else
            send_pair(20'($urandom()), 20'($urandom()), 1'b0, zero_res);
        if ($urandom_range(0, 2) == 0) idle_gap();
      end
      s_axis_tvalid <= 1'b0;
    end

    drain();
    $display("Checked %0d result words (%0d with zero divisor) over 11 calibration sets,",
             n_words, n_invalid);
    $display("including a long output stall with the input kept busy.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
rtl/ptc_pkg.sv
rtl/ptc_cal_regs.sv
rtl/ptc_divider.sv
rtl/pressure_temperature_compensation.sv
bench/tb_pressure_temperature_compensation.sv
